[hdl/ptc_pkg.sv]
// Shared types and constants for the point-to-circle projection block.
`default_nettype none

package ptc_pkg;

    // Fixed field widths
    localparam int RADIUS_BITS = 10;
    localparam int OFFSET_BITS = 11;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // Register reset values
    localparam int CENTRE_X_RESET = 320;
    localparam int CENTRE_Y_RESET = 240;
    localparam int RADIUS_RESET   = 100;

    // Register indexes (word address bits of paddr)
    typedef enum logic [1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } reg_index_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ROOT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[hdl/point_to_circle_projection.sv]
// Point-to-circle projection: bit-serial square, root and divide sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid / in_stall    | pointer_col, pointer_row
//  out     | output    | out_valid / out_stall  | offset_x, offset_y, moved
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// An item runs through the multiply, root and divide loops, each handling one bit per
// cycle; a zero vector skips the loops and goes straight to the result phase.
// Reset (rst_n low) restores the register defaults and clears the last result.
// in_stall is high while an item is at work; the result sits in an output
// register, so a new item is taken while out_stall holds the previous result.
`default_nettype none

module point_to_circle_projection #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              in_valid,
    output       logic                              in_stall,
    input  wire  logic [COORD_BITS-1:0]             pointer_col,
    input  wire  logic [COORD_BITS-1:0]             pointer_row,
    output       logic                              out_valid,
    input  wire  logic                              out_stall,
    output       logic signed [ptc_pkg::OFFSET_BITS-1:0] offset_x,
    output       logic signed [ptc_pkg::OFFSET_BITS-1:0] offset_y,
    output       logic                              moved,
    input  wire  logic                              psel,
    input  wire  logic                              penable,
    input  wire  logic                              pwrite,
    input  wire  logic [ptc_pkg::ADDR_BITS-1:0]     paddr,
    input  wire  logic [ptc_pkg::DATA_BITS-1:0]     pwdata,
    output       logic [ptc_pkg::DATA_BITS-1:0]     prdata,
    output       logic                              pready
);
    import ptc_pkg::*;

    localparam int SW  = 2 * COORD_BITS + 2;         // square sum width
    localparam int RW  = COORD_BITS + FRAC_BITS + 1; // root width
    localparam int REMW = RW + 2;                    // root remainder width
    localparam int PW  = RADIUS_BITS + COORD_BITS;   // radius * delta width
    localparam int NW  = PW + FRAC_BITS;             // dividend width
    localparam int CW  = $clog2(NW + 1);             // step counter width

    // Configuration registers
    logic [COORD_BITS-1:0]  centre_x_reg;
    logic [COORD_BITS-1:0]  centre_y_reg;
    logic [RADIUS_BITS-1:0] radius_reg;

    // Control state
    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OFFSET_BITS-1:0] last_x_reg, last_x_next;
    logic [OFFSET_BITS-1:0] last_y_reg, last_y_next;

    // Datapath registers
    logic                   nx_reg, ny_reg, zero_reg;
    logic [COORD_BITS-1:0]  mplx_reg, mply_reg;
    logic [SW-1:0]          mcx_reg, mcy_reg;
    logic [PW-1:0]          rsh_reg;
    logic [SW-1:0]          sq_reg;
    logic [PW-1:0]          prodx_reg, prody_reg;
    logic [REMW-1:0]        rem_reg;
    logic [RW-1:0]          root_reg;
    logic [NW-1:0]          nx_sh_reg, ny_sh_reg;
    logic [RW-1:0]          remx_reg, remy_reg;
    logic [OFFSET_BITS-1:0] offset_x_reg, offset_y_reg;
    logic                   moved_reg;

    logic                   cfg_wr;
    logic                   in_acc;
    logic                   load_out;
    logic [COORD_BITS-1:0]  ax, ay;
    logic                   col_lt, row_lt;
    logic [REMW-1:0]        rem_t, trial;
    logic [RW:0]            tx, ty, lq_ext;
    logic                   qx_bit, qy_bit;
    logic [OFFSET_BITS-1:0] res_x, res_y;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign offset_x  = offset_x_reg;
    assign offset_y  = offset_y_reg;
    assign moved     = moved_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= COORD_BITS'(CENTRE_X_RESET);
            centre_y_reg <= COORD_BITS'(CENTRE_Y_RESET);
            radius_reg   <= RADIUS_BITS'(RADIUS_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CENTRE_X: centre_x_reg <= pwdata[COORD_BITS-1:0];
                REG_CENTRE_Y: centre_y_reg <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:   radius_reg   <= pwdata[RADIUS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_CENTRE_X: prdata = DATA_BITS'(centre_x_reg);
            REG_CENTRE_Y: prdata = DATA_BITS'(centre_y_reg);
            REG_RADIUS:   prdata = DATA_BITS'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    // Form delta magnitudes and signs
    always_comb
    begin
        col_lt = pointer_col < centre_x_reg;
        row_lt = pointer_row < centre_y_reg;
        ax = col_lt ? centre_x_reg - pointer_col : pointer_col - centre_x_reg;
        ay = row_lt ? centre_y_reg - pointer_row : pointer_row - centre_y_reg;
    end

    // One root digit: bring down a pair, try root*4+1
    always_comb
    begin
        rem_t = {rem_reg[REMW-3:0], sq_reg[SW-1:SW-2]};
        trial = {root_reg, 2'b01};
    end

    // One quotient bit per lane
    always_comb
    begin
        lq_ext = {1'b0, root_reg};
        tx     = {remx_reg, nx_sh_reg[NW-1]};
        ty     = {remy_reg, ny_sh_reg[NW-1]};
        qx_bit = (tx >= lq_ext);
        qy_bit = (ty >= lq_ext);
    end

    // Apply signs to the quotients
    always_comb
    begin
        if (zero_reg)
        begin
            res_x = '0;
            res_y = '0;
        end
        else
        begin
            res_x = nx_reg ? OFFSET_BITS'(-nx_sh_reg[OFFSET_BITS-1:0])
                           : nx_sh_reg[OFFSET_BITS-1:0];
            res_y = ny_reg ? OFFSET_BITS'(-ny_sh_reg[OFFSET_BITS-1:0])
                           : ny_sh_reg[OFFSET_BITS-1:0];
        end
    end

    // Sequence the phases
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (ax == '0 && ay == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        cnt_next   = CW'(COORD_BITS - 1);
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = CW'(RW - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV;
                    cnt_next   = CW'(NW - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    last_x_next    = res_x;
                    last_y_next    = res_y;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
        end
    end

    // Advance the serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    nx_reg    <= col_lt;
                    ny_reg    <= row_lt;
                    zero_reg  <= (ax == '0 && ay == '0);
                    mplx_reg  <= ax;
                    mply_reg  <= ay;
                    mcx_reg   <= SW'(ax);
                    mcy_reg   <= SW'(ay);
                    rsh_reg   <= PW'(radius_reg);
                    sq_reg    <= '0;
                    prodx_reg <= '0;
                    prody_reg <= '0;
                end
            end
            ST_MUL:
            begin
                // shift-add: ax*ax + ay*ay, radius*ax, radius*ay
                sq_reg <= sq_reg + (mplx_reg[0] ? mcx_reg : '0)
                                 + (mply_reg[0] ? mcy_reg : '0);
                prodx_reg <= prodx_reg + (mplx_reg[0] ? rsh_reg : '0);
                prody_reg <= prody_reg + (mply_reg[0] ? rsh_reg : '0);
                mplx_reg  <= mplx_reg >> 1;
                mply_reg  <= mply_reg >> 1;
                mcx_reg   <= mcx_reg << 1;
                mcy_reg   <= mcy_reg << 1;
                rsh_reg   <= rsh_reg << 1;
                if (cnt_reg == '0)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                if (rem_t >= trial)
                begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                sq_reg <= sq_reg << 2;
                if (cnt_reg == '0)
                begin
                    nx_sh_reg <= {prodx_reg, {FRAC_BITS{1'b0}}};
                    ny_sh_reg <= {prody_reg, {FRAC_BITS{1'b0}}};
                    remx_reg  <= '0;
                    remy_reg  <= '0;
                end
            end
            ST_DIV:
            begin
                remx_reg  <= qx_bit ? RW'(tx - lq_ext) : tx[RW-1:0];
                remy_reg  <= qy_bit ? RW'(ty - lq_ext) : ty[RW-1:0];
                nx_sh_reg <= {nx_sh_reg[NW-2:0], qx_bit};
                ny_sh_reg <= {ny_sh_reg[NW-2:0], qy_bit};
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    offset_x_reg <= res_x;
                    offset_y_reg <= res_y;
                    moved_reg    <= (res_x != last_x_reg) || (res_y != last_y_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    // A new result appears only out of the final phase
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid without finishing the item");

    // Non-negative projected offsets never exceed the radius
    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !offset_x_reg[OFFSET_BITS-1])
            |-> (offset_x_reg[OFFSET_BITS-2:0] <= radius_reg))
        else $error("offset_x beyond radius");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !offset_y_reg[OFFSET_BITS-1])
            |-> (offset_y_reg[OFFSET_BITS-2:0] <= radius_reg))
        else $error("offset_y beyond radius");

    // The stored last result follows each delivered result
    a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (last_x_reg == offset_x_reg) && (last_y_reg == offset_y_reg))
        else $error("last result not updated with output");
`endif

endmodule

`default_nettype wire

[bench/ptc_checker.sv]
// Checker for the point-to-circle projection block: predicts each result and compares it.
`default_nettype none

module ptc_checker #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_stall,
    input  wire logic [COORD_BITS-1:0]                  pointer_col,
    input  wire logic [COORD_BITS-1:0]                  pointer_row,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_stall,
    input  wire logic signed [ptc_pkg::OFFSET_BITS-1:0] offset_x,
    input  wire logic signed [ptc_pkg::OFFSET_BITS-1:0] offset_y,
    input  wire logic                                   moved,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic                                   pready,
    input  wire logic [ptc_pkg::ADDR_BITS-1:0]          paddr,
    input  wire logic [ptc_pkg::DATA_BITS-1:0]          pwdata,
    output int                                          error_count,
    output int                                          pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    typedef struct {
        logic signed [OFFSET_BITS-1:0] px;
        logic signed [OFFSET_BITS-1:0] py;
        logic                          mv;
    } projection_t;

    projection_t projection_q[$];

    // Shadow copy of the registers and the last result
    logic [COORD_BITS-1:0]  centre_col  = COORD_BITS'(CENTRE_X_RESET);
    logic [COORD_BITS-1:0]  centre_row  = COORD_BITS'(CENTRE_Y_RESET);
    logic [RADIUS_BITS-1:0] circle_r    = RADIUS_BITS'(RADIUS_RESET);
    logic [OFFSET_BITS-1:0] prev_x      = '0;
    logic [OFFSET_BITS-1:0] prev_y      = '0;
    int                     mismatches  = 0;
    int                     outstanding = 0;

    assign error_count   = mismatches;
    assign pending_count = outstanding;

    // trunc(r * mag * 2^FRAC_BITS / lq), negated where needed, kept to the offset width
    function automatic logic [OFFSET_BITS-1:0] scaled_offset(input logic [63:0] mag,
                                                             input logic        neg,
                                                             input logic [63:0] r,
                                                             input logic [63:0] lq);
        logic [63:0] q;
        q = ((r * mag) << FRAC_BITS) / lq;
        if (neg)
            q = -q;
        return q[OFFSET_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        logic [63:0]  col, row, cx, cy, ax, ay, sq, rem, root, trial, pair;
        logic         nx, ny;
        logic [OFFSET_BITS-1:0] nxt_x, nxt_y;
        projection_t  fresh, oldest;
        int           i;

        if (!rst_n)
        begin
            centre_col = COORD_BITS'(CENTRE_X_RESET);
            centre_row = COORD_BITS'(CENTRE_Y_RESET);
            circle_r   = RADIUS_BITS'(RADIUS_RESET);
            prev_x     = '0;
            prev_y     = '0;
            projection_q.delete();
        end
        else
        begin
            // Track register writes; unknown indexes drop out
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_BITS-1:2])
                    REG_CENTRE_X: centre_col = pwdata[COORD_BITS-1:0];
                    REG_CENTRE_Y: centre_row = pwdata[COORD_BITS-1:0];
                    REG_RADIUS:   circle_r   = pwdata[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end

            // Predict the result of each accepted item
            if (in_valid && !in_stall)
            begin
                col = 64'(pointer_col);
                row = 64'(pointer_row);
                cx  = 64'(centre_col);
                cy  = 64'(centre_row);
                nx  = col < cx;
                ny  = row < cy;
                ax  = nx ? cx - col : col - cx;
                ay  = ny ? cy - row : row - cy;
                sq  = ax * ax + ay * ay;
                nxt_x = '0;
                nxt_y = '0;
                if (sq != 0)
                begin
                    // Digit-by-digit root carried into the fraction bits
                    rem  = 0;
                    root = 0;
                    for (i = COORD_BITS; i >= -FRAC_BITS; i--)
                    begin
                        if (i >= 0)
                            pair = (sq >> (2 * i)) & 64'd3;
                        else
                            pair = 0;
                        rem   = (rem << 2) | pair;
                        trial = (root << 2) | 64'd1;
                        if (rem >= trial)
                        begin
                            rem  = rem - trial;
                            root = (root << 1) | 64'd1;
                        end
                        else
                            root = root << 1;
                    end
                    nxt_x = scaled_offset(ax, nx, 64'(circle_r), root);
                    nxt_y = scaled_offset(ay, ny, 64'(circle_r), root);
                end
                fresh.px = nxt_x;
                fresh.py = nxt_y;
                fresh.mv = (nxt_x != prev_x) || (nxt_y != prev_y);
                prev_x   = nxt_x;
                prev_y   = nxt_y;
                projection_q.push_back(fresh);
            end

            // Compare each delivered result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (projection_q.size() == 0)
                begin
                    $error("unexpected result: offset_x %0d offset_y %0d moved %0d",
                           offset_x, offset_y, moved);
                    mismatches++;
                end
                else
                begin
                    oldest = projection_q.pop_front();
                    if (offset_x !== oldest.px)
                    begin
                        $error("offset_x: expected %0d, actual %0d", oldest.px, offset_x);
                        mismatches++;
                    end
                    if (offset_y !== oldest.py)
                    begin
                        $error("offset_y: expected %0d, actual %0d", oldest.py, offset_y);
                        mismatches++;
                    end
                    if (moved !== oldest.mv)
                    begin
                        $error("moved: expected %0d, actual %0d", oldest.mv, moved);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = projection_q.size();
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench top: clock, reset, stimulus and verdict for the point-to-circle projection block.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int REG_UNUSED  = 3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [COORD_BITS-1:0]         pointer_col;
    logic [COORD_BITS-1:0]         pointer_row;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [OFFSET_BITS-1:0] offset_x;
    logic signed [OFFSET_BITS-1:0] offset_y;
    logic                          moved;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_BITS-1:0]          paddr;
    logic [DATA_BITS-1:0]          pwdata;
    logic [DATA_BITS-1:0]          prdata;
    logic                          pready;

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   quiet       = 1'b0;
    bit   hold_go     = 1'b0;

    point_to_circle_projection #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pointer_col (pointer_col),
        .pointer_row (pointer_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .moved       (moved),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ptc_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) projection_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pointer_col   (pointer_col),
        .pointer_row   (pointer_row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .moved         (moved),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_side
        bit hold_ack;
        int hold_left;
        hold_ack  = 1'b0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go != hold_ack)
            begin
                hold_ack  = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = !quiet && ($urandom_range(99) < 11);
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_point(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 11)
        begin
            in_valid    = 1'b0;
            pointer_col = COORD_BITS'($urandom_range(COORD_MAX));
            pointer_row = COORD_BITS'($urandom_range(COORD_MAX));
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        pointer_col = col;
        pointer_row = row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Two-phase register write; junk fills the bits above the field
    task automatic write_reg(input int idx, input logic [RADIUS_BITS-1:0] val,
                             input logic [DATA_BITS-1:0] junk);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BITS'(idx * 4);
        pwdata  = {junk[DATA_BITS-1:RADIUS_BITS], val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input int cx, input int cy, input int r, input bit junky);
        wait_drained();
        write_reg(REG_CENTRE_X, RADIUS_BITS'(cx), junky ? $urandom : '0);
        write_reg(REG_CENTRE_Y, RADIUS_BITS'(cy), junky ? $urandom : '0);
        write_reg(REG_RADIUS,   RADIUS_BITS'(r),  junky ? $urandom : '0);
    endtask

    // Coordinate a few steps from c, clamped to the field range
    function automatic logic [COORD_BITS-1:0] near_coord(input int c);
        int v;
        v = c + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return COORD_BITS'(v);
    endfunction

    // Stimulus and verdict
    initial
    begin : stimulus
        int phase;
        int n;
        int pick;
        int cx;
        int cy;
        int r;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pointer_col = '0;
        pointer_row = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero vector, repeats, corners and unit steps
        send_point(10'd320, 10'd240);
        send_point(10'd320, 10'd240);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd0, 10'd1023);
        send_point(10'd320, 10'd0);
        send_point(10'd0, 10'd240);
        send_point(10'd321, 10'd240);
        send_point(10'd320, 10'd241);
        send_point(10'd321, 10'd241);
        send_point(10'd321, 10'd241);

        // Centre in the corner, largest radius; stray write to an unused index
        apply_config(0, 0, 1023, 1'b1);
        write_reg(REG_UNUSED, 10'd777, $urandom);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd1, 10'd0);
        send_point(10'd0, 10'd1);
        send_point(10'd1023, 10'd1);

        // Zero radius
        apply_config(1023, 1023, 0, 1'b0);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd512, 10'd7);

        // Unit radius
        apply_config(1023, 0, 1, 1'b1);
        send_point(10'd0, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd1022, 10'd1);

        // Random phases, each under its own settings
        col = '0;
        row = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            cx = $urandom_range(COORD_MAX);
            cy = $urandom_range(COORD_MAX);
            r  = $urandom_range(COORD_MAX);
            case (phase)
                1: begin cx = 0;    cy = 0;    r = 1023; end
                3: begin cx = 1023; cy = 1023; r = 0;    end
                5: begin cx = 1023; cy = 0;    r = 1;    end
                6: r = 1023;
                default: ;
            endcase
            apply_config(cx, cy, r, 1'b1);
            quiet = (phase == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off the result side while items keep coming
                if (phase == 4 && n == 40)
                    hold_go = ~hold_go;
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    // repeat the last point so moved can drop
                end
                else if (pick < 20)
                begin
                    col = COORD_BITS'(cx);
                    row = COORD_BITS'(cy);
                end
                else if (pick < 40)
                begin
                    col = near_coord(cx);
                    row = near_coord(cy);
                end
                else
                begin
                    col = COORD_BITS'($urandom_range(COORD_MAX));
                    row = COORD_BITS'($urandom_range(COORD_MAX));
                end
                send_point(col, row);
            end
            quiet = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/ptc_pkg.sv
hdl/point_to_circle_projection.sv
bench/ptc_checker.sv
bench/tb_top.sv
